[rtl/tcw_pkg.sv]
// Package for the text console writer: sequencer state type, operation codes,
// newline code, register indexes and reset values. No dependencies.
`default_nettype none

package tcw_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCR_RD,
        S_SCR_WR,
        S_FILL,
        S_DONE
    } t_state;

    // Operation codes carried in the input tuser
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Character code that moves the cursor to the next row
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    // Configuration register indexes
    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    // Colour reset values
    localparam logic [3:0] FG_RESET = 4'd10;
    localparam logic [3:0] BG_RESET = 4'd0;

endpackage : tcw_pkg

`default_nettype wire

[rtl/text_console_writer.sv]
// Text console writer top level: sequencer, cursor, colour registers and output
// register. Depends on tcw_pkg, tcw_ram and tcw_agu.
//
// Usage: commands enter on the s_axis channel (tuser = opcode, tdata = character,
// read row, read column); each command gives exactly one result on m_axis (cell
// character and attribute for a read, cursor position after the command, scroll
// flag). Colours are written through the cfg channel, index 0 foreground and
// index 1 background; the user must write them only while idle (not enforced).
// Timing: the block takes one command at a time. A put character or newline
// passes through the execute and done states; a read adds a wait state for the
// registered read of the cell store. A put that scrolls copies each cell up one
// row through a read state and a write state, then blanks the bottom row. A clear
// sweeps the store at one cell a cycle.
// Reset: the cursor homes, colours return to their defaults and a clearing pass
// writes zero to every cell, with s_axis_tready low until it ends.
// Stall: the result waits in the output register; a following command is taken
// as soon as that register is free or being emptied.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [3:0]  i_cfg_data,
    // Command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // char_code[7:0], cell_row[12:8], cell_col[19:13]
    input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // cell_char[7:0], cell_attr[15:8],
                                            // cursor_row[20:16], cursor_col[27:21],
                                            // scrolled[28]
);

    localparam int N     = ROWS * COLUMNS;
    localparam int AW    = $clog2(N);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int ARW   = (RW > 5) ? RW : 5;
    localparam int OFW   = (AW > 8) ? AW : 8;
    localparam int SW    = ((ARW + 9) > OFW ? (ARW + 9) : OFW) + 1;

    localparam logic [AW-1:0] ADDR_LAST = AW'(N - 1);
    localparam logic [AW-1:0] SCR_LAST  = AW'((ROWS - 1) * COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);

    tcw_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_addr, n_addr;
    logic [15:0]   r_fill_data, n_fill_data;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [3:0]    r_fg, r_bg;
    logic          r_rd_ok, n_rd_ok;
    logic [7:0]    r_res_char, n_res_char;
    logic [7:0]    r_res_attr, n_res_attr;
    logic          r_res_scr, n_res_scr;
    logic          r_out_valid;
    logic [31:0]   r_out_data;

    logic [1:0]    r_op;
    logic [7:0]    r_ch;
    logic [4:0]    r_rrow;
    logic [6:0]    r_rcol;

    logic          in_accept;
    logic          out_load;
    logic          adv;
    logic          rd_in_range;
    logic [7:0]    attr;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    logic [ARW-1:0] agu_row;
    logic [OFW-1:0] agu_off;
    logic           agu_inc;
    logic [SW-1:0]  agu_sum;

    logic [RW+4:0] row_ext;
    logic [CW+6:0] col_ext;

    assign attr        = {r_bg, r_fg};
    assign in_accept   = s_axis_tvalid && s_axis_tready;
    assign rd_in_range = ({3'b000, r_rrow} < 8'(ROWS)) && ({2'b00, r_rcol} < 9'(COLUMNS));
    assign row_ext     = {5'b00000, r_row};
    assign col_ext     = {7'b0000000, r_col};

    // Cell store
    tcw_ram #(
        .WIDTH(16),
        .DEPTH(N)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Shared address unit
    tcw_agu #(
        .COLUMNS(COLUMNS),
        .ROW_W  (ARW),
        .OFF_W  (OFW),
        .SUM_W  (SW)
    ) u_agu (
        .i_row(agu_row),
        .i_off(agu_off),
        .i_inc(agu_inc),
        .o_sum(agu_sum)
    );

    // Configuration: always ready; the user must write only while idle (not enforced)
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= tcw_pkg::FG_RESET;
            r_bg <= tcw_pkg::BG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tcw_pkg::CFG_FG: r_fg <= i_cfg_data;
                tcw_pkg::CFG_BG: r_bg <= i_cfg_data;
            endcase
        end
    end

    // Capture the command on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= s_axis_tuser;
            r_ch   <= s_axis_tdata[7:0];
            r_rrow <= s_axis_tdata[12:8];
            r_rcol <= s_axis_tdata[19:13];
        end
    end

    // Sequencer and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::S_INIT;
            r_addr      <= '0;
            r_fill_data <= '0;
            r_row       <= '0;
            r_col       <= '0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_fill_data <= n_fill_data;
            r_row       <= n_row;
            r_col       <= n_col;
        end
    end

    // Result staging
    always_ff @(posedge i_clk) begin
        r_rd_ok    <= n_rd_ok;
        r_res_char <= n_res_char;
        r_res_attr <= n_res_attr;
        r_res_scr  <= n_res_scr;
    end

    // Next state, store access and address unit operands
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_fill_data = r_fill_data;
        n_row       = r_row;
        n_col       = r_col;
        n_rd_ok     = r_rd_ok;
        n_res_char  = r_res_char;
        n_res_attr  = r_res_attr;
        n_res_scr   = r_res_scr;
        s_axis_tready = 1'b0;
        out_load    = 1'b0;
        adv         = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_addr;
        ram_raddr   = agu_sum[AW-1:0];
        ram_wdata   = r_fill_data;
        agu_row     = '0;
        agu_off     = OFW'(r_addr);
        agu_inc     = 1'b0;

        unique case (r_state)
            // Clearing pass after reset: zero every cell
            tcw_pkg::S_INIT: begin
                ram_we  = 1'b1;
                agu_inc = 1'b1;
                n_addr  = agu_sum[AW-1:0];
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = tcw_pkg::S_IDLE;
                end
            end

            tcw_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = tcw_pkg::S_EXEC;
                end
            end

            tcw_pkg::S_EXEC: begin
                n_res_char = '0;
                n_res_attr = '0;
                n_res_scr  = 1'b0;
                n_state    = tcw_pkg::S_DONE;
                unique case (r_op)
                    tcw_pkg::OP_PUT: begin
                        agu_row   = ARW'(r_row);
                        agu_off   = OFW'(r_col);
                        ram_waddr = agu_sum[AW-1:0];
                        ram_wdata = {attr, r_ch};
                        if (r_ch == tcw_pkg::NEWLINE_CODE) begin
                            n_col = '0;
                            adv   = 1'b1;
                        end else begin
                            ram_we = 1'b1;
                            if (r_col == COL_LAST) begin
                                n_col = '0;
                                adv   = 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        // Past the bottom row: scroll and stay on the bottom row
                        if (adv) begin
                            if (r_row == ROW_LAST) begin
                                n_res_scr   = 1'b1;
                                n_addr      = '0;
                                n_fill_data = {attr, 8'h00};
                                n_state     = tcw_pkg::S_SCR_RD;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end
                    end
                    tcw_pkg::OP_READ: begin
                        agu_row = ARW'(r_rrow);
                        agu_off = OFW'(r_rcol);
                        ram_re  = rd_in_range;
                        n_rd_ok = rd_in_range;
                        n_state = tcw_pkg::S_RDWAIT;
                    end
                    tcw_pkg::OP_CLEAR: begin
                        n_row       = '0;
                        n_col       = '0;
                        n_addr      = '0;
                        n_fill_data = {attr, 8'h00};
                        n_state     = tcw_pkg::S_FILL;
                    end
                    default: begin
                        n_state = tcw_pkg::S_DONE;
                    end
                endcase
            end

            // Take the registered cell, or zero when out of range
            tcw_pkg::S_RDWAIT: begin
                n_res_char = r_rd_ok ? ram_rdata[7:0]  : 8'h00;
                n_res_attr = r_rd_ok ? ram_rdata[15:8] : 8'h00;
                n_state    = tcw_pkg::S_DONE;
            end

            // Scroll: read the cell one row below
            tcw_pkg::S_SCR_RD: begin
                agu_row = ARW'(1);
                ram_re  = 1'b1;
                n_state = tcw_pkg::S_SCR_WR;
            end

            // Scroll: write it back one row up, advance
            tcw_pkg::S_SCR_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                agu_inc   = 1'b1;
                n_addr    = agu_sum[AW-1:0];
                if (r_addr == SCR_LAST) begin
                    n_state = tcw_pkg::S_FILL;
                end else begin
                    n_state = tcw_pkg::S_SCR_RD;
                end
            end

            // Blank cells from the current address to the end of the store
            tcw_pkg::S_FILL: begin
                ram_we  = 1'b1;
                agu_inc = 1'b1;
                n_addr  = agu_sum[AW-1:0];
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = tcw_pkg::S_DONE;
                end
            end

            // Hand the result over once the output register is free
            tcw_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load      = 1'b1;
                    s_axis_tready = 1'b1;
                    if (s_axis_tvalid) begin
                        n_state = tcw_pkg::S_EXEC;
                    end else begin
                        n_state = tcw_pkg::S_IDLE;
                    end
                end
            end

            default: begin
                n_state = tcw_pkg::S_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {3'b000, r_res_scr, col_ext[6:0], row_ext[4:0],
                           r_res_attr, r_res_char};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule : text_console_writer

`default_nettype wire

[rtl/tcw_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; hold the last data when not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : tcw_ram

`default_nettype wire

[rtl/tcw_agu.sv]
// Shared address unit of the text console writer: row * COLUMNS + offset + inc.
// Serves cursor writes, cell reads, scroll copies and fill sweeps. No dependencies.
`default_nettype none

module tcw_agu #(
    parameter int COLUMNS = 80,
    parameter int ROW_W   = 5,
    parameter int OFF_W   = 11,
    parameter int SUM_W   = 15
) (
    input  wire logic [ROW_W-1:0] i_row,
    input  wire logic [OFF_W-1:0] i_off,
    input  wire logic             i_inc,
    output logic      [SUM_W-1:0] o_sum
);

    localparam logic [8:0] COLS = 9'(COLUMNS);

    logic [ROW_W+8:0] prod;

    // Row base, then offset and step
    assign prod  = i_row * COLS;
    assign o_sum = SUM_W'(prod) + SUM_W'(i_off) + SUM_W'(i_inc);

endmodule : tcw_agu

`default_nettype wire
